@@ src/snmp_pkg.sv @@
// ----------------------------------------------------------------------------
// snmp_pkg
// shared types and constants for the snmp response ber parser
// ----------------------------------------------------------------------------
package snmp_pkg;

    localparam int MAX_DATAGRAM_DEF = 2048;

    localparam logic [4:0] PH_OUT_TAG  = 5'd0;
    localparam logic [4:0] PH_OUT_LEN  = 5'd1;
    localparam logic [4:0] PH_LIST_LEN = 5'd20;
    localparam logic [4:0] PH_VB_TAG   = 5'd21;
    localparam logic [4:0] PH_NAME_TAG = 5'd23;
    localparam logic [4:0] PH_VAL_TAG  = 5'd26;
    localparam logic [4:0] PH_VAL_LEN  = 5'd27;
    localparam logic [4:0] PH_VAL_BODY = 5'd28;
    localparam logic [4:0] PH_VB_SKIP  = 5'd29;
    localparam logic [4:0] PH_DONE     = 5'd30;
    localparam logic [4:0] PH_FAILED   = 5'd31;

    localparam logic [1:0] ROLE_TAG  = 2'd0;
    localparam logic [1:0] ROLE_LEN  = 2'd1;
    localparam logic [1:0] ROLE_BODY = 2'd2;
    localparam logic [1:0] ROLE_MISC = 2'd3;

    localparam logic [2:0] K_NAME_ARC = 3'd0;
    localparam logic [2:0] K_VAL_ARC  = 3'd1;
    localparam logic [2:0] K_VAL_NUM  = 3'd2;
    localparam logic [2:0] K_TEXT     = 3'd3;
    localparam logic [2:0] K_VB_END   = 3'd4;
    localparam logic [2:0] K_STATUS   = 3'd5;

    localparam logic [3:0] T_NULL = 4'd0;
    localparam logic [3:0] T_INT  = 4'd1;
    localparam logic [3:0] T_C32  = 4'd2;
    localparam logic [3:0] T_G32  = 4'd3;
    localparam logic [3:0] T_TT   = 4'd4;
    localparam logic [3:0] T_OCT  = 4'd5;
    localparam logic [3:0] T_OID  = 4'd6;
    localparam logic [3:0] T_OTH  = 4'd7;
    localparam logic [3:0] T_NSO  = 4'd8;
    localparam logic [3:0] T_NSI  = 4'd9;
    localparam logic [3:0] T_EOM  = 4'd10;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] number;
        logic [3:0]  value_type;
        logic [7:0]  text_byte;
        logic        bad_response;
    } res_t;

    typedef struct packed {
        logic [2:0] count;
        res_t [3:0] res;
    } res_group_t;

    function automatic logic [1:0] phase_role(input logic [4:0] ph);
        logic [1:0] r;
        case (ph)
            5'd0, 5'd2, 5'd5, 5'd8, 5'd10, 5'd13, 5'd16, 5'd19, 5'd21, 5'd23, 5'd26:
                r = ROLE_TAG;
            5'd1, 5'd3, 5'd6, 5'd9, 5'd11, 5'd14, 5'd17, 5'd20, 5'd22, 5'd24, 5'd27:
                r = ROLE_LEN;
            5'd4, 5'd7, 5'd12, 5'd15, 5'd18, 5'd25, 5'd28:
                r = ROLE_BODY;
            default: r = ROLE_MISC;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] phase_tag(input logic [4:0] ph);
        logic [7:0] t;
        case (ph)
            5'd0, 5'd19, 5'd21: t = 8'h30;
            5'd2, 5'd10, 5'd13, 5'd16: t = 8'h02;
            5'd5:  t = 8'h04;
            5'd8:  t = 8'hA2;
            5'd23: t = 8'h06;
            default: t = 8'h00;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] type_code(input logic [7:0] tag);
        logic [3:0] c;
        unique case (tag)
            8'h05: c = T_NULL;
            8'h02: c = T_INT;
            8'h41: c = T_C32;
            8'h42: c = T_G32;
            8'h43: c = T_TT;
            8'h04: c = T_OCT;
            8'h06: c = T_OID;
            8'h80: c = T_NSO;
            8'h81: c = T_NSI;
            8'h82: c = T_EOM;
            default: c = T_OTH;
        endcase
        return c;
    endfunction

endpackage

@@ src/snmp_fsm.sv @@
// ----------------------------------------------------------------------------
// snmp_fsm
// byte-wise ber walk: state update and the results caused by one byte
// ----------------------------------------------------------------------------
module snmp_fsm
    import snmp_pkg::*;
#(
    parameter int MAX_DATAGRAM = MAX_DATAGRAM_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] octet,
    input  logic       last,
    output res_group_t group
);

    localparam int CW = $clog2(MAX_DATAGRAM + 2);
    localparam int RW = 12;
    localparam logic [CW-1:0] MAXD = CW'(MAX_DATAGRAM);

    logic [4:0]    phase_reg, phase_next;
    logic [31:0]   lacc_reg, lacc_next;
    logic [2:0]    lleft_reg, lleft_next;
    logic [RW-1:0] outer_reg, outer_next, pdu_reg, pdu_next, list_reg, list_next;
    logic [RW-1:0] vb_reg, vb_next, elem_reg, elem_next;
    logic [63:0]   arc_reg, arc_next, vacc_reg, vacc_next;
    logic          first_reg, first_next;
    logic [7:0]    vtag_reg, vtag_next;
    logic          any_reg, any_next, err_reg, err_next;
    logic [CW-1:0] bcnt_reg, bcnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OUT_TAG;
            lacc_reg  <= '0;
            lleft_reg <= '0;
            outer_reg <= '0;
            pdu_reg   <= '0;
            list_reg  <= '0;
            vb_reg    <= '0;
            elem_reg  <= '0;
            arc_reg   <= '0;
            vacc_reg  <= '0;
            first_reg <= 1'b1;
            vtag_reg  <= '0;
            any_reg   <= 1'b0;
            err_reg   <= 1'b0;
            bcnt_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            lacc_reg  <= lacc_next;
            lleft_reg <= lleft_next;
            outer_reg <= outer_next;
            pdu_reg   <= pdu_next;
            list_reg  <= list_next;
            vb_reg    <= vb_next;
            elem_reg  <= elem_next;
            arc_reg   <= arc_next;
            vacc_reg  <= vacc_next;
            first_reg <= first_next;
            vtag_reg  <= vtag_next;
            any_reg   <= any_next;
            err_reg   <= err_next;
            bcnt_reg  <= bcnt_next;
        end
    end

    // comb scratch
    logic [1:0]    role;
    logic          ok, len_done, len_bad;
    logic [31:0]   ln, room;
    logic [63:0]   arc_new;
    logic [3:0]    ty;
    logic [7:0]    shown;
    logic          bad;
    res_group_t    g;

    function automatic res_t mk(input logic [2:0] k, input logic [63:0] n,
                                input logic [3:0] t, input logic [7:0] x, input logic b);
        res_t r;
        r.kind = k; r.number = n; r.value_type = t; r.text_byte = x; r.bad_response = b;
        return r;
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        lacc_next  = lacc_reg;
        lleft_next = lleft_reg;
        outer_next = outer_reg;
        pdu_next   = pdu_reg;
        list_next  = list_reg;
        vb_next    = vb_reg;
        elem_next  = elem_reg;
        arc_next   = arc_reg;
        vacc_next  = vacc_reg;
        first_next = first_reg;
        vtag_next  = vtag_reg;
        any_next   = any_reg;
        err_next   = err_reg;
        bcnt_next  = bcnt_reg;
        g          = '0;
        ok         = 1'b1;
        len_done   = 1'b0;
        len_bad    = 1'b0;
        ln         = '0;
        room       = '0;
        arc_new    = '0;
        ty         = type_code(vtag_reg);
        shown      = octet;
        bad        = 1'b0;

        if (bcnt_reg <= MAXD)
            bcnt_next = bcnt_reg + CW'(1);
        if (bcnt_next > MAXD && phase_reg != PH_FAILED)
        begin
            phase_next = PH_FAILED;
            err_next   = 1'b1;
        end

        role = phase_role(phase_next);
        if (phase_next != PH_FAILED)
        begin
            ok = 1'b1;
            if (role == ROLE_BODY && elem_reg == '0)
                ok = 1'b0;
            else if (phase_next >= 5'd2 && phase_next <= 5'd9)
                ok = outer_reg != '0;
            else if (phase_next >= 5'd10 && phase_next <= PH_LIST_LEN)
                ok = pdu_reg != '0;
            else if (phase_next == PH_VB_TAG || phase_next == 5'd22)
                ok = list_reg != '0;
            else if (phase_next >= PH_NAME_TAG && phase_next <= PH_VB_SKIP)
                ok = vb_reg != '0;

            if (!ok)
            begin
                phase_next = PH_FAILED;
                err_next   = 1'b1;
            end
            else
            begin
                if (phase_reg >= 5'd2 && phase_reg <= PH_DONE && outer_reg != '0)
                    outer_next = outer_reg - RW'(1);
                if (phase_reg >= 5'd10 && phase_reg <= PH_DONE && pdu_reg != '0)
                    pdu_next = pdu_reg - RW'(1);
                if (phase_reg >= PH_VB_TAG && phase_reg <= PH_VB_SKIP && list_reg != '0)
                    list_next = list_reg - RW'(1);
                if (phase_reg >= PH_NAME_TAG && phase_reg <= PH_VB_SKIP && vb_reg != '0)
                    vb_next = vb_reg - RW'(1);
                if (role == ROLE_BODY && elem_reg != '0)
                    elem_next = elem_reg - RW'(1);

                unique case (role)
                    ROLE_TAG:
                    begin
                        if (phase_reg == PH_VAL_TAG)
                        begin
                            vtag_next  = octet;
                            phase_next = phase_reg + 5'd1;
                            lleft_next = '0;
                            lacc_next  = '0;
                        end
                        else if (octet != phase_tag(phase_reg))
                        begin
                            phase_next = PH_FAILED;
                            err_next   = 1'b1;
                        end
                        else
                        begin
                            phase_next = phase_reg + 5'd1;
                            lleft_next = '0;
                            lacc_next  = '0;
                        end
                    end
                    ROLE_LEN:
                    begin
                        if (lleft_reg == '0)
                        begin
                            if (!octet[7])
                            begin
                                lacc_next = {24'd0, octet};
                                len_done  = 1'b1;
                            end
                            else if (octet[6:0] == 7'd0 || octet[6:0] > 7'd4)
                                len_bad = 1'b1;
                            else
                            begin
                                lleft_next = octet[2:0];
                                lacc_next  = '0;
                            end
                        end
                        else
                        begin
                            lacc_next  = {lacc_reg[23:0], octet};
                            lleft_next = lleft_reg - 3'd1;
                            len_done   = lleft_reg == 3'd1;
                        end
                        ln = lacc_next;
                        if (len_bad)
                        begin
                            phase_next = PH_FAILED;
                            err_next   = 1'b1;
                        end
                        else if (len_done)
                        begin
                            case (phase_reg)
                                PH_OUT_LEN:
                                begin
                                    room = (bcnt_next < MAXD) ?
                                           32'(MAXD - bcnt_next) : 32'd0;
                                    outer_next = RW'((ln < room) ? ln : room);
                                    phase_next = 5'd2;
                                end
                                5'd3, 5'd6, 5'd11, 5'd14, 5'd17, 5'd24:
                                begin
                                    if (phase_reg == 5'd24)
                                    begin
                                        first_next = 1'b1;
                                        arc_next   = '0;
                                    end
                                    if (ln > 32'((phase_reg == 5'd3 || phase_reg == 5'd6) ?
                                        outer_next : (phase_reg == 5'd24 ? vb_next : pdu_next)))
                                    begin
                                        phase_next = PH_FAILED;
                                        err_next   = 1'b1;
                                    end
                                    else
                                    begin
                                        elem_next  = RW'(ln);
                                        phase_next = (ln != '0) ? phase_reg + 5'd1
                                                                : phase_reg + 5'd2;
                                    end
                                end
                                5'd9:
                                begin
                                    if (ln > 32'(outer_next))
                                    begin
                                        phase_next = PH_FAILED;
                                        err_next   = 1'b1;
                                    end
                                    else
                                    begin
                                        pdu_next   = RW'(ln);
                                        phase_next = 5'd10;
                                    end
                                end
                                PH_LIST_LEN:
                                begin
                                    if (ln > 32'(pdu_next))
                                    begin
                                        phase_next = PH_FAILED;
                                        err_next   = 1'b1;
                                    end
                                    else
                                    begin
                                        list_next  = RW'(ln);
                                        phase_next = (ln != '0) ? PH_VB_TAG : PH_DONE;
                                    end
                                end
                                5'd22:
                                begin
                                    if (ln > 32'(list_next))
                                    begin
                                        phase_next = PH_FAILED;
                                        err_next   = 1'b1;
                                    end
                                    else
                                    begin
                                        vb_next    = RW'(ln);
                                        phase_next = PH_NAME_TAG;
                                    end
                                end
                                default:
                                begin
                                    if (ln > 32'(vb_next))
                                    begin
                                        phase_next = PH_FAILED;
                                        err_next   = 1'b1;
                                    end
                                    else
                                    begin
                                        first_next = 1'b1;
                                        arc_next   = '0;
                                        vacc_next  = '0;
                                        elem_next  = RW'(ln);
                                        if (ln != '0)
                                            phase_next = PH_VAL_BODY;
                                        else
                                        begin
                                            if (ty >= T_INT && ty <= T_TT)
                                            begin
                                                g.res[g.count[1:0]] =
                                                    mk(K_VAL_NUM, 64'd0, ty, 8'd0, 1'b0);
                                                g.count = g.count + 3'd1;
                                            end
                                            if (vb_next == '0)
                                            begin
                                                g.res[g.count[1:0]] =
                                                    mk(K_VB_END, 64'd0, ty, 8'd0, 1'b0);
                                                g.count    = g.count + 3'd1;
                                                any_next   = 1'b1;
                                                phase_next = (list_next != '0) ? PH_VB_TAG : PH_DONE;
                                            end
                                            else
                                                phase_next = PH_VB_SKIP;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                    ROLE_BODY:
                    begin
                        arc_new = {arc_reg[56:0], octet[6:0]};
                        if (phase_reg == PH_VAL_BODY)
                        begin
                            if (ty == T_INT)
                                vacc_next = {(first_reg ? {56{octet[7]}} : vacc_reg[55:0]), octet};
                            if (ty == T_INT)
                                first_next = 1'b0;
                            if (ty >= T_C32 && ty <= T_TT)
                                vacc_next = {vacc_reg[55:0], octet};
                            if (ty == T_OCT)
                            begin
                                if ((octet < 8'h20 || octet >= 8'h7F) && octet != 8'h09 &&
                                    octet != 8'h0A && octet != 8'h0D)
                                    shown = 8'h3F;
                                g.res[g.count[1:0]] = mk(K_TEXT, 64'd0, T_OCT, shown, 1'b0);
                                g.count = g.count + 3'd1;
                            end
                            if (ty == T_OTH)
                            begin
                                g.res[g.count[1:0]] = mk(K_TEXT, 64'd0, T_OTH, octet, 1'b0);
                                g.count = g.count + 3'd1;
                            end
                            if (ty == T_OID)
                            begin
                                arc_next = arc_new;
                                if (!octet[7] || elem_next == '0)
                                begin
                                    if (first_reg)
                                    begin
                                        if (arc_new < 64'd40)
                                        begin
                                            g.res[0] = mk(K_VAL_ARC, 64'd0, T_OID, 8'd0, 1'b0);
                                            g.res[1] = mk(K_VAL_ARC, arc_new, T_OID, 8'd0, 1'b0);
                                        end
                                        else if (arc_new < 64'd80)
                                        begin
                                            g.res[0] = mk(K_VAL_ARC, 64'd1, T_OID, 8'd0, 1'b0);
                                            g.res[1] = mk(K_VAL_ARC, arc_new - 64'd40, T_OID,
                                                          8'd0, 1'b0);
                                        end
                                        else
                                        begin
                                            g.res[0] = mk(K_VAL_ARC, 64'd2, T_OID, 8'd0, 1'b0);
                                            g.res[1] = mk(K_VAL_ARC, arc_new - 64'd80, T_OID,
                                                          8'd0, 1'b0);
                                        end
                                        g.count = 3'd2;
                                        first_next = 1'b0;
                                    end
                                    else
                                    begin
                                        g.res[0] = mk(K_VAL_ARC, arc_new, T_OID, 8'd0, 1'b0);
                                        g.count = 3'd1;
                                    end
                                    arc_next = '0;
                                end
                            end
                            if (elem_next == '0)
                            begin
                                if (ty >= T_INT && ty <= T_TT)
                                begin
                                    g.res[g.count[1:0]] = mk(K_VAL_NUM, vacc_next, ty, 8'd0, 1'b0);
                                    g.count = g.count + 3'd1;
                                end
                                if (vb_next == '0)
                                begin
                                    g.res[g.count[1:0]] = mk(K_VB_END, 64'd0, ty, 8'd0, 1'b0);
                                    g.count    = g.count + 3'd1;
                                    any_next   = 1'b1;
                                    phase_next = (list_next != '0) ? PH_VB_TAG : PH_DONE;
                                end
                                else
                                    phase_next = PH_VB_SKIP;
                            end
                        end
                        else
                        begin
                            if (phase_reg == 5'd25)
                            begin
                                arc_next = arc_new;
                                if (!octet[7] || elem_next == '0)
                                begin
                                    if (first_reg)
                                    begin
                                        if (arc_new < 64'd40)
                                        begin
                                            g.res[0] = mk(K_NAME_ARC, 64'd0, T_NULL, 8'd0, 1'b0);
                                            g.res[1] = mk(K_NAME_ARC, arc_new, T_NULL, 8'd0, 1'b0);
                                        end
                                        else if (arc_new < 64'd80)
                                        begin
                                            g.res[0] = mk(K_NAME_ARC, 64'd1, T_NULL, 8'd0, 1'b0);
                                            g.res[1] = mk(K_NAME_ARC, arc_new - 64'd40, T_NULL,
                                                          8'd0, 1'b0);
                                        end
                                        else
                                        begin
                                            g.res[0] = mk(K_NAME_ARC, 64'd2, T_NULL, 8'd0, 1'b0);
                                            g.res[1] = mk(K_NAME_ARC, arc_new - 64'd80, T_NULL,
                                                          8'd0, 1'b0);
                                        end
                                        g.count = 3'd2;
                                        first_next = 1'b0;
                                    end
                                    else
                                    begin
                                        g.res[0] = mk(K_NAME_ARC, arc_new, T_NULL, 8'd0, 1'b0);
                                        g.count = 3'd1;
                                    end
                                    arc_next = '0;
                                end
                            end
                            if (elem_next == '0)
                                phase_next = phase_reg + 5'd1;
                        end
                    end
                    default:
                    begin
                        if (phase_reg == PH_VB_SKIP && vb_next == '0)
                        begin
                            g.res[g.count[1:0]] = mk(K_VB_END, 64'd0, ty, 8'd0, 1'b0);
                            g.count    = g.count + 3'd1;
                            any_next   = 1'b1;
                            phase_next = (list_next != '0) ? PH_VB_TAG : PH_DONE;
                        end
                    end
                endcase
            end
        end

        if (last)
        begin
            bad = err_next || phase_next != PH_DONE || pdu_next != '0 || !any_next;
            if (g.count < 3'd4)
            begin
                g.res[g.count[1:0]] = mk(K_STATUS, 64'd0, T_NULL, 8'd0, bad);
                g.count = g.count + 3'd1;
            end
            phase_next = PH_OUT_TAG;
            lacc_next  = '0;
            lleft_next = '0;
            outer_next = '0;
            pdu_next   = '0;
            list_next  = '0;
            vb_next    = '0;
            elem_next  = '0;
            arc_next   = '0;
            vacc_next  = '0;
            first_next = 1'b1;
            vtag_next  = '0;
            any_next   = 1'b0;
            err_next   = 1'b0;
            bcnt_next  = '0;
        end
        group = g;
    end

`ifndef ASSERT_OFF
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> group.count <= 3'd4)
        else $error("too many results");
    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_FAILED && !last) |=> phase_reg == PH_FAILED)
        else $error("left failed state");
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FAILED |-> err_reg)
        else $error("failed without error flag");
`endif

endmodule

@@ src/snmp_response_ber_parser.sv @@
// ----------------------------------------------------------------------------
// snmp_response_ber_parser
// streaming ber decoder for snmpv2c get-response datagrams
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one datagram byte per item, tlast marks the last byte
//   m_axis carries decoded results: arcs, numbers, text bytes, varbind ends
//   and a packet status on the last byte; tlast marks the last result of
//   the input byte that caused it
// throughput: one byte per cycle while results flow and each byte causes at
//   most one result; a byte with more results hands them over one per cycle
// the first result of a byte appears in the cycle after the byte is accepted
// bytes that cause no result leave nothing pending and still need a free
//   result slot
// reset: parse state returns to the outer sequence tag, result register
//   empties
// stall: while m_axis_tready is low the pending result group holds and
//   s_axis_tready drops once the group can not be handed over
// ----------------------------------------------------------------------------
module snmp_response_ber_parser
    import snmp_pkg::*;
#(
    parameter int MAX_DATAGRAM = MAX_DATAGRAM_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tlast,   // end_of_datagram
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // number, value_type, text_byte, pad
    output logic [3:0]  m_axis_tuser,   // kind, bad_response
    output logic        m_axis_tlast    // last_of_run
);

    res_group_t grp_next, grp_reg;
    logic [2:0] idx_reg;
    logic       have_reg;
    logic       step;
    logic       done_now;
    res_t       cur;

    assign done_now      = have_reg && m_axis_tready && (idx_reg + 3'd1 >= grp_reg.count);
    assign s_axis_tready = !have_reg || done_now;
    assign step          = s_axis_tvalid && s_axis_tready;

    snmp_fsm #(.MAX_DATAGRAM(MAX_DATAGRAM)) u_fsm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .octet (s_axis_tdata),
        .last  (s_axis_tlast),
        .group (grp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (step)
        begin
            have_reg <= grp_next.count != '0;
            idx_reg  <= '0;
        end
        else if (done_now)
        begin
            have_reg <= 1'b0;
        end
        else if (have_reg && m_axis_tready)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            grp_reg <= grp_next;
    end

    assign cur           = grp_reg.res[idx_reg[1:0]];
    assign m_axis_tvalid = have_reg;
    assign m_axis_tdata  = {4'd0, cur.text_byte, cur.value_type, cur.number};
    assign m_axis_tuser  = {cur.bad_response, cur.kind};
    assign m_axis_tlast  = idx_reg + 3'd1 >= grp_reg.count;

`ifndef ASSERT_OFF
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        have_reg |-> idx_reg < grp_reg.count)
        else $error("result index out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (have_reg && !m_axis_tready) |=> have_reg && $stable(idx_reg))
        else $error("result dropped under stall");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        (have_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");
`endif

endmodule

@@ tb/tb_snmp_response_ber_parser.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_snmp_response_ber_parser
// self-checking bench for the streaming snmpv2c get-response decoder
//
// random response datagrams, mostly well formed, with random oids, value
// types, length forms and trailers; the rest truncated, corrupted or noise
// scoreboard decodes every accepted byte and compares each result item
// field by field; until two thirds of the bytes are sent both sides idle at random
// ----------------------------------------------------------------------------
module tb_snmp_response_ber_parser;
    import snmp_pkg::*;

    typedef logic [7:0] bytes_t[$];

    typedef struct {
        res_t r;
        logic last;
    } decoded_t;

    class decode_scoreboard;
        localparam int unsigned DGRAM_MAX = 2048;
        byte unsigned role_of[32] = '{
            0,1,0,1,2,0,1,2,0,1, 0,1,2,0,1,2,0,1,2, 0,1, 0,1, 0,1,2, 0,1,2, 3,3,3};
        byte unsigned tag_of[32] = '{
            8'h30,0,8'h02,0,0,8'h04,0,0,8'hA2,0, 8'h02,0,0,8'h02,0,0,8'h02,0,0,
            8'h30,0, 8'h30,0, 8'h06,0,0, 0,0,0, 0,0,0};

        int unsigned phase, len_acc, len_left, outer_left, pdu_left, list_left;
        int unsigned vb_left, elem_left, first_arc, val_tag, seen_vb, err, nbytes;
        logic [63:0] arc_acc, val_acc;
        res_t step_out[$];
        decoded_t pending[$];
        int errors, checked;

        function new();
            clear_all();
            errors = 0;
            checked = 0;
        endfunction

        function void clear_all();
            phase = PH_OUT_TAG; len_acc = 0; len_left = 0;
            outer_left = 0; pdu_left = 0; list_left = 0; vb_left = 0; elem_left = 0;
            arc_acc = 0; val_acc = 0; first_arc = 1; val_tag = 0;
            seen_vb = 0; err = 0; nbytes = 0;
        endfunction

        function void emit(logic [2:0] k, logic [63:0] n, logic [3:0] t,
                           logic [7:0] x, logic b);
            res_t r;
            r.kind = k; r.number = n; r.value_type = t; r.text_byte = x;
            r.bad_response = b;
            if (step_out.size() < 4)
                step_out = {step_out, r};
        endfunction

        function logic [3:0] type_of(int unsigned tag);
            case (tag)
                8'h05: return T_NULL;
                8'h02: return T_INT;
                8'h41: return T_C32;
                8'h42: return T_G32;
                8'h43: return T_TT;
                8'h04: return T_OCT;
                8'h06: return T_OID;
                8'h80: return T_NSO;
                8'h81: return T_NSI;
                8'h82: return T_EOM;
                default: return T_OTH;
            endcase
        endfunction

        function void fail();
            phase = PH_FAILED;
            err = 1;
        endfunction

        function void emit_arc(logic [2:0] k, logic [3:0] t);
            logic [63:0] c;
            c = arc_acc;
            if (first_arc != 0)
            begin
                if (c < 64'd80)
                begin
                    emit(k, c / 64'd40, t, 8'd0, 1'b0);
                    emit(k, c % 64'd40, t, 8'd0, 1'b0);
                end
                else
                begin
                    emit(k, 64'd2, t, 8'd0, 1'b0);
                    emit(k, c - 64'd80, t, 8'd0, 1'b0);
                end
                first_arc = 0;
            end
            else
            begin
                emit(k, c, t, 8'd0, 1'b0);
            end
            arc_acc = 0;
        endfunction

        function void vb_end();
            emit(K_VB_END, 64'd0, type_of(val_tag), 8'd0, 1'b0);
            seen_vb = 1;
            phase = (list_left != 0) ? PH_VB_TAG : PH_DONE;
        endfunction

        function void value_end();
            logic [3:0] t;
            t = type_of(val_tag);
            if (t >= T_INT && t <= T_TT)
                emit(K_VAL_NUM, val_acc, t, 8'd0, 1'b0);
            if (vb_left == 0)
                vb_end();
            else
                phase = PH_VB_SKIP;
        endfunction

        function bit bound_ok(int unsigned ph);
            if (role_of[ph] == 2 && elem_left == 0) return 0;
            if (ph >= 2 && ph <= 9) return outer_left > 0;
            if (ph >= 10 && ph <= PH_LIST_LEN) return pdu_left > 0;
            if (ph == PH_VB_TAG || ph == PH_VB_TAG + 1) return list_left > 0;
            if (ph >= PH_NAME_TAG && ph <= PH_VB_SKIP) return vb_left > 0;
            return 1;
        endfunction

        function void consume(int unsigned ph);
            if (ph >= 2 && ph <= PH_DONE && outer_left > 0) outer_left--;
            if (ph >= 10 && ph <= PH_DONE && pdu_left > 0) pdu_left--;
            if (ph >= PH_VB_TAG && ph <= PH_VB_SKIP && list_left > 0) list_left--;
            if (ph >= PH_NAME_TAG && ph <= PH_VB_SKIP && vb_left > 0) vb_left--;
            if (role_of[ph] == 2 && elem_left > 0) elem_left--;
        endfunction

        // 1 complete, 0 more length bytes, -1 malformed
        function int take_length(int unsigned b);
            int unsigned cnt;
            if (len_left == 0)
            begin
                if ((b & 8'h80) == 0)
                begin
                    len_acc = b;
                    return 1;
                end
                cnt = b & 8'h7F;
                if (cnt == 0 || cnt > 4) return -1;
                len_left = cnt;
                len_acc = 0;
                return 0;
            end
            len_acc = (len_acc << 8) | b;
            len_left--;
            return (len_left == 0) ? 1 : 0;
        endfunction

        function void open_body(int unsigned ph, int unsigned ln, int unsigned lim);
            if (ln > lim)
            begin
                fail();
                return;
            end
            elem_left = ln;
            phase = (ln != 0) ? ph + 1 : ph + 2;
        endfunction

        function void length_done(int unsigned ph, int unsigned ln);
            int unsigned room;
            case (ph)
                PH_OUT_LEN:
                begin
                    room = (nbytes < DGRAM_MAX) ? DGRAM_MAX - nbytes : 0;
                    outer_left = (ln < room) ? ln : room;
                    phase = 2;
                end
                3, 6: open_body(ph, ln, outer_left);
                11, 14, 17: open_body(ph, ln, pdu_left);
                9:
                begin
                    if (ln > outer_left)
                        fail();
                    else
                    begin
                        pdu_left = ln;
                        phase = 10;
                    end
                end
                PH_LIST_LEN:
                begin
                    if (ln > pdu_left)
                        fail();
                    else
                    begin
                        list_left = ln;
                        phase = (ln != 0) ? PH_VB_TAG : PH_DONE;
                    end
                end
                PH_VB_TAG + 1:
                begin
                    if (ln > list_left)
                        fail();
                    else
                    begin
                        vb_left = ln;
                        phase = PH_NAME_TAG;
                    end
                end
                PH_NAME_TAG + 1:
                begin
                    first_arc = 1;
                    arc_acc = 0;
                    open_body(ph, ln, vb_left);
                end
                default:
                begin
                    if (ln > vb_left)
                        fail();
                    else
                    begin
                        first_arc = 1; arc_acc = 0; val_acc = 0;
                        elem_left = ln;
                        if (ln != 0)
                            phase = PH_VAL_BODY;
                        else
                            value_end();
                    end
                end
            endcase
        endfunction

        function void value_byte(logic [7:0] b);
            logic [3:0] t;
            logic [7:0] shown;
            t = type_of(val_tag);
            if (t == T_INT)
            begin
                if (first_arc != 0)
                begin
                    val_acc = b[7] ? {64{1'b1}} : 64'd0;
                    first_arc = 0;
                end
                val_acc = {val_acc[55:0], b};
            end
            else if (t >= T_C32 && t <= T_TT)
            begin
                val_acc = {val_acc[55:0], b};
            end
            else if (t == T_OCT)
            begin
                shown = b;
                if ((b < 8'h20 || b >= 8'h7F) && b != 8'h09 && b != 8'h0A && b != 8'h0D)
                    shown = 8'h3F;
                emit(K_TEXT, 64'd0, T_OCT, shown, 1'b0);
            end
            else if (t == T_OID)
            begin
                arc_acc = {arc_acc[56:0], b[6:0]};
                if (!b[7] || elem_left == 0)
                    emit_arc(K_VAL_ARC, T_OID);
            end
            else if (t == T_OTH)
            begin
                emit(K_TEXT, 64'd0, T_OTH, b, 1'b0);
            end
            if (elem_left == 0)
                value_end();
        endfunction

        function void process(int unsigned ph, logic [7:0] b);
            int st;
            case (role_of[ph])
                0:
                begin
                    if (ph == PH_VAL_TAG)
                        val_tag = b;
                    else if (b != tag_of[ph])
                    begin
                        fail();
                        return;
                    end
                    len_left = 0;
                    len_acc = 0;
                    phase = ph + 1;
                end
                1:
                begin
                    st = take_length(b);
                    if (st < 0)
                        fail();
                    else if (st > 0)
                        length_done(ph, len_acc);
                end
                2:
                begin
                    if (ph == PH_VAL_BODY)
                        value_byte(b);
                    else
                    begin
                        if (ph == PH_NAME_TAG + 2)
                        begin
                            arc_acc = {arc_acc[56:0], b[6:0]};
                            if (!b[7] || elem_left == 0)
                                emit_arc(K_NAME_ARC, T_NULL);
                        end
                        if (elem_left == 0)
                            phase = ph + 1;
                    end
                end
                default:
                    if (ph == PH_VB_SKIP && vb_left == 0)
                        vb_end();
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic eod);
            int unsigned ph;
            logic bad;
            decoded_t d;
            step_out.delete();
            if (nbytes <= DGRAM_MAX) nbytes++;
            if (nbytes > DGRAM_MAX && phase != PH_FAILED) fail();
            ph = phase;
            if (ph != PH_FAILED)
            begin
                if (!bound_ok(ph))
                    fail();
                else
                begin
                    consume(ph);
                    process(ph, b);
                end
            end
            if (eod)
            begin
                bad = (err != 0 || phase != PH_DONE || pdu_left != 0 || seen_vb == 0);
                emit(K_STATUS, 64'd0, T_NULL, 8'd0, bad);
                clear_all();
            end
            foreach (step_out[i])
            begin
                d.r = step_out[i];
                d.last = (i == step_out.size() - 1);
                pending = {pending, d};
            end
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_item(res_t got, logic got_last);
            decoded_t e;
            checked++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected item kind %0d", got.kind));
                return;
            end
            e = pending.pop_front();
            if (got.kind !== e.r.kind)
                report($sformatf("kind %0d want %0d", got.kind, e.r.kind));
            if (got.number !== e.r.number)
                report($sformatf("number %h want %h", got.number, e.r.number));
            if (got.value_type !== e.r.value_type)
                report($sformatf("type %0d want %0d", got.value_type, e.r.value_type));
            if (got.text_byte !== e.r.text_byte)
                report($sformatf("text %h want %h", got.text_byte, e.r.text_byte));
            if (got.bad_response !== e.r.bad_response)
                report($sformatf("bad %b want %b", got.bad_response, e.r.bad_response));
            if (got_last !== e.last)
                report($sformatf("tlast %b want %b", got_last, e.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    decode_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int dgram_count;
    int byte_count;

    snmp_response_ber_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind = m_axis_tuser[2:0];
            got.bad_response = m_axis_tuser[3];
            got.number = m_axis_tdata[63:0];
            got.value_type = m_axis_tdata[67:64];
            got.text_byte = m_axis_tdata[75:68];
            sb.check_item(got, m_axis_tlast);
        end
    end

    function automatic bytes_t enc_len(int unsigned n);
        bytes_t q;
        int k;
        if (n < 128 && $urandom_range(3) != 0)
        begin
            q = {q, n[7:0]};
            return q;
        end
        k = (n < 256) ? 1 : (n < 65536) ? 2 : 3;
        k = k + $urandom_range(4 - k);
        q = {q, 8'h80 | k[7:0]};
        for (int i = k - 1; i >= 0; i--)
            q = {q, 8'((n >> (8 * i)) & 8'hFF)};
        return q;
    endfunction

    function automatic bytes_t tlv(logic [7:0] tag, bytes_t body);
        bytes_t q;
        q = {q, tag};
        q = {q, enc_len(body.size()), body};
        return q;
    endfunction

    function automatic bytes_t rand_bytes(int lo, int hi, int hi_pct);
        bytes_t q;
        int n;
        logic [7:0] b;
        n = $urandom_range(hi, lo);
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(255));
            b[7] = ($urandom_range(99) < hi_pct);
            q = {q, b};
        end
        return q;
    endfunction

    function automatic bytes_t oid_body(int lo, int hi);
        bytes_t q;
        q = rand_bytes(lo, hi, 40);
        if (q.size() > 0 && $urandom_range(4) != 0)
            q[q.size() - 1][7] = 1'b0;
        return q;
    endfunction

    function automatic bytes_t make_varbind();
        logic [7:0] tags[11] = '{8'h05, 8'h02, 8'h41, 8'h42, 8'h43, 8'h04, 8'h06,
                                 8'h80, 8'h81, 8'h82, 8'h44};
        logic [7:0] tag;
        bytes_t val;
        bytes_t vb;
        tag = tags[$urandom_range(10)];
        if ($urandom_range(19) == 0)
            tag = 8'($urandom_range(255));
        case (tag)
            8'h05, 8'h80, 8'h81, 8'h82: val = rand_bytes(0, ($urandom_range(7) == 0), 50);
            8'h06: val = oid_body(0, 6);
            8'h04: val = rand_bytes(0, 6, 30);
            default: val = rand_bytes(0, 10, 50);
        endcase
        vb = {tlv(8'h06, oid_body(0, 7)), tlv(tag, val)};
        if ($urandom_range(4) == 0)
            vb = {vb, rand_bytes(1, 2, 50)};
        return tlv(8'h30, vb);
    endfunction

    function automatic bytes_t make_response();
        bytes_t list;
        bytes_t pdu;
        bytes_t msg;
        int n;
        n = ($urandom_range(9) == 0) ? 0 : $urandom_range(3, 1);
        for (int i = 0; i < n; i++)
            list = {list, make_varbind()};
        pdu = {tlv(8'h02, rand_bytes(0, 4, 50)), tlv(8'h02, rand_bytes(1, 1, 50)),
               tlv(8'h02, rand_bytes(1, 1, 50)), tlv(8'h30, list)};
        if ($urandom_range(5) == 0)
            pdu = {pdu, rand_bytes(1, 2, 50)};
        msg = {tlv(8'h02, rand_bytes(1, 1, 0)), tlv(8'h04, rand_bytes(0, 6, 10)),
               tlv(8'hA2, pdu)};
        msg = tlv(8'h30, msg);
        if ($urandom_range(5) == 0)
            msg = {msg, rand_bytes(1, 3, 50)};
        return msg;
    endfunction

    task automatic send_dgram(bytes_t q);
        for (int i = 0; i < q.size(); i++)
        begin
            if ($urandom_range(99) < tx_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= q[i];
            s_axis_tlast <= (i == q.size() - 1);
            do @(posedge clk); while (!s_axis_tready);
            sb.note_byte(q[i], i == q.size() - 1);
            byte_count++;
        end
        dgram_count++;
    endtask

    initial
    begin
        #2000000;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

    initial
    begin
        bytes_t q;
        int sel;
        int pos;
        int target;
        sb = new();
        dgram_count = 0;
        byte_count = 0;
        tx_idle_pct = 11;
        rx_idle_pct = 60;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tlast = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short malformed frames, reserved and overlong length forms
        send_dgram('{8'h30});
        send_dgram('{8'h30, 8'h80, 8'h02});
        send_dgram('{8'h30, 8'h85, 8'hFF});
        // minimal response with an empty varbind list
        send_dgram('{8'h30, 8'h0E, 8'h02, 8'h01, 8'h01, 8'h04, 8'h00, 8'hA2, 8'h08,
                     8'h02, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00, 8'h30, 8'h00});

        target = 405;
        while (byte_count < target)
        begin
            if (byte_count > target / 3 && tx_idle_pct == 11)
            begin
                tx_idle_pct = 60;
                rx_idle_pct = 11;
            end
            else if (byte_count > 2 * target / 3 && tx_idle_pct == 60)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            q = make_response();
            sel = $urandom_range(99);
            if (sel < 12)
            begin
                pos = $urandom_range(q.size() - 1);
                q[pos] = 8'($urandom_range(255));
            end
            else if (sel < 22)
            begin
                q = q[0:$urandom_range(q.size() - 1)];
            end
            else if (sel < 27)
            begin
                q = rand_bytes(1, 8, 50);
            end
            send_dgram(q);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d datagrams, %0d bytes", dgram_count, byte_count);
        $display("checked %0d decoded items, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
src/snmp_pkg.sv
src/snmp_fsm.sv
src/snmp_response_ber_parser.sv
tb/tb_snmp_response_ber_parser.sv
